@@ rtl/sac_pkg.sv @@
// Shared types, codes and constants for the stepper axis controller.
package sac_pkg;

	localparam int unsigned POSITION_WIDTH_DEF = 24;
	localparam int unsigned VALUE_W            = 24;
	localparam int unsigned AXIS_MAX_W         = 23;
	localparam logic [AXIS_MAX_W-1:0] AXIS_MAX_RST = 23'd4200;
	localparam logic        SENSOR_HIGH_RST    = 1'b1;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_REL  = 2'd1,
		MODE_ABS  = 2'd2,
		MODE_HOME = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic {
		REG_AXIS_MAX    = 1'b0,
		REG_SENSOR_HIGH = 1'b1
	} cfg_reg_t;

	// full-step drive pattern, bit3 is the first coil
	function automatic logic [3:0] phase_coils(input logic [1:0] phase);
		logic [3:0] pat;
		case (phase)
			2'd0:    pat = 4'h9;
			2'd1:    pat = 4'hC;
			2'd2:    pat = 4'h6;
			2'd3:    pat = 4'h3;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

@@ rtl/stepper_axis_controller.sv @@
// Stepper axis controller: one full-step unipolar axis with endstops and homing.
// A word passes the input register, then the state update and the result register,
//   which are both written in one pass.
// Throughput: one word per cycle; the input register takes a new word when it is
//   empty, or when its word moves on because the result register is empty or drains.
// Reset (arst_n low, async): axis stopped, position/target/phase 0, coils off,
//   axis_max 4200, sensors active high, no words in flight.
module stepper_axis_controller
	import sac_pkg::*;
#(
	parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // move_value[23:0], home_level[24], ext_level[25]
	input  logic [1:0]            s_tuser,   // mode[1:0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,   // coils[3:0], is_moving[4], is_homing[5],
	                                         // position_out[29:6], target_out[53:30]
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [AXIS_MAX_W-1:0] cfg_data
);

	localparam int unsigned PW = POSITION_WIDTH;
	// arithmetic width: covers position, 24-bit move value and their sum
	localparam int unsigned CW = ((PW > VALUE_W) ? PW : VALUE_W) + 2;
	localparam logic signed [CW-1:0] POS_MAX_X = CW'((64'sd1 <<< (PW - 1)) - 64'sd1);
	localparam logic signed [CW-1:0] POS_MIN_X = -POS_MAX_X - CW'(1);
	localparam logic signed [PW-1:0] POS_MAX   = POS_MAX_X[PW-1:0];
	localparam logic signed [PW-1:0] POS_MIN   = POS_MIN_X[PW-1:0];

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [AXIS_MAX_W-1:0] axis_max_q;
	logic                  sens_high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_max_q  <= AXIS_MAX_RST;
			sens_high_q <= SENSOR_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_AXIS_MAX:    axis_max_q  <= cfg_data;
				REG_SENSOR_HIGH: sens_high_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stage 1: input register
	// ---------------------------------------------------------------
	logic                      valid_s1;
	mode_t                     mode_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic                      home_s1;
	logic                      ext_s1;
	logic                      valid_s2;
	logic                      advance;

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1  <= mode_t'(s_tuser);
			value_s1 <= s_tdata[VALUE_W-1:0];
			home_s1  <= s_tdata[VALUE_W];
			ext_s1   <= s_tdata[VALUE_W+1];
		end
	end

	// ---------------------------------------------------------------
	// axis state
	// ---------------------------------------------------------------
	logic [1:0]           phase_q;
	logic signed [PW-1:0] pos_q;
	logic signed [PW-1:0] tgt_q;
	dir_t                 dir_q;
	logic                 moving_q;
	logic                 homing_q;
	logic [3:0]           coil_q;

	logic [1:0]           phase_d;
	logic signed [PW-1:0] pos_d;
	logic signed [PW-1:0] tgt_d;
	dir_t                 dir_d;
	logic                 moving_d;
	logic                 homing_d;
	logic [3:0]           coil_d;

	// move target arithmetic
	logic signed [CW-1:0] pos_x;
	logic signed [CW-1:0] tgt_x;
	logic signed [CW-1:0] val_x;
	logic signed [CW-1:0] amax_x;
	logic signed [CW-1:0] hi_x;
	logic signed [CW-1:0] rel_sum;
	logic signed [CW-1:0] rel_t;
	logic signed [CW-1:0] abs_t;
	logic signed [CW-1:0] goto_x;
	logic signed [PW-1:0] goto_t;

	// one step in the current direction
	logic [1:0]           step_phase;
	logic signed [PW-1:0] step_pos;
	logic [3:0]           step_coil;

	logic home_hit;
	logic ext_hit;

	always_comb begin
		pos_x  = {{(CW-PW){pos_q[PW-1]}}, pos_q};
		tgt_x  = {{(CW-PW){tgt_q[PW-1]}}, tgt_q};
		val_x  = {{(CW-VALUE_W){value_s1[VALUE_W-1]}}, value_s1};
		amax_x = {{(CW-AXIS_MAX_W){1'b0}}, axis_max_q};
		hi_x   = (amax_x > POS_MAX_X) ? POS_MAX_X : amax_x;

		// relative move: base is the target while moving, clamp to 0..hi
		rel_sum = (moving_q ? tgt_x : pos_x) + val_x;
		if (rel_sum < CW'(0)) begin
			rel_t = '0;
		end else if (rel_sum > hi_x) begin
			rel_t = hi_x;
		end else begin
			rel_t = rel_sum;
		end

		// absolute move: saturate into the position range
		if (val_x > POS_MAX_X) begin
			abs_t = POS_MAX_X;
		end else if (val_x < POS_MIN_X) begin
			abs_t = POS_MIN_X;
		end else begin
			abs_t = val_x;
		end

		goto_x = (mode_s1 == MODE_REL) ? rel_t : abs_t;
		goto_t = goto_x[PW-1:0];
	end

	always_comb begin
		step_phase = phase_q;
		step_pos   = pos_q;
		case (dir_q)
			DIR_UP: begin
				step_phase = phase_q + 2'd1;
				step_pos   = (pos_q == POS_MAX) ? pos_q : pos_q + PW'(1);
			end
			DIR_DOWN: begin
				step_phase = phase_q - 2'd1;
				step_pos   = (pos_q == POS_MIN) ? pos_q : pos_q - PW'(1);
			end
			default: ;
		endcase
		step_coil = phase_coils(step_phase);
	end

	assign home_hit = (home_s1 == sens_high_q);
	assign ext_hit  = (ext_s1 == sens_high_q);

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		tgt_d    = tgt_q;
		dir_d    = dir_q;
		moving_d = moving_q;
		homing_d = homing_q;
		coil_d   = coil_q;

		case (mode_s1)
			MODE_TICK: begin
				if (moving_q) begin
					if (homing_q) begin
						if (home_hit) begin
							pos_d    = '0;
							tgt_d    = '0;
							homing_d = 1'b0;
							moving_d = 1'b0;
							coil_d   = '0;
						end else begin
							phase_d = step_phase;
							pos_d   = step_pos;
							coil_d  = step_coil;
						end
					end else if (dir_q == DIR_DOWN && home_hit) begin
						pos_d    = '0;
						tgt_d    = '0;
						moving_d = 1'b0;
						coil_d   = '0;
					end else if (dir_q == DIR_UP && ext_hit) begin
						tgt_d    = pos_q;
						moving_d = 1'b0;
						coil_d   = '0;
					end else if (pos_q == tgt_q) begin
						moving_d = 1'b0;
						coil_d   = '0;
					end else begin
						phase_d = step_phase;
						pos_d   = step_pos;
						coil_d  = step_coil;
					end
				end
			end
			MODE_REL, MODE_ABS: begin
				// a move onto the current position is dropped
				if (goto_t != pos_q) begin
					tgt_d    = goto_t;
					dir_d    = (goto_t > pos_q) ? DIR_UP : DIR_DOWN;
					moving_d = 1'b1;
					homing_d = 1'b0;
				end
			end
			MODE_HOME: begin
				homing_d = 1'b1;
				dir_d    = DIR_DOWN;
				moving_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			pos_q    <= '0;
			tgt_q    <= '0;
			dir_q    <= DIR_NONE;
			moving_q <= 1'b0;
			homing_q <= 1'b0;
			coil_q   <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			tgt_q    <= tgt_d;
			dir_q    <= dir_d;
			moving_q <= moving_d;
			homing_q <= homing_d;
			coil_q   <= coil_d;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: result register
	// ---------------------------------------------------------------
	logic signed [CW-1:0] pos_out_x;
	logic signed [CW-1:0] tgt_out_x;
	logic [3:0]           coils_s2;
	logic                 moving_s2;
	logic                 homing_s2;
	logic [VALUE_W-1:0]   pos_s2;
	logic [VALUE_W-1:0]   tgt_s2;

	assign pos_out_x = {{(CW-PW){pos_d[PW-1]}}, pos_d};
	assign tgt_out_x = {{(CW-PW){tgt_d[PW-1]}}, tgt_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coils_s2  <= coil_d;
			moving_s2 <= moving_d;
			homing_s2 <= homing_d;
			pos_s2    <= pos_out_x[VALUE_W-1:0];
			tgt_s2    <= tgt_out_x[VALUE_W-1:0];
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, tgt_s2, pos_s2, homing_s2, moving_s2, coils_s2};

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_coils_off_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		!moving_q |-> coil_q == 4'h0)
		else $error("coils driven while axis is stopped");

	a_homing_implies_moving: assert property (@(posedge clk) disable iff (!arst_n)
		homing_q |-> moving_q && dir_q == DIR_DOWN)
		else $error("homing active without downward motion");

	a_moving_has_direction: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> dir_q != DIR_NONE)
		else $error("axis moving with no direction");

	a_stalled_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |-> !advance ##1 valid_s2)
		else $error("stage 1 overwrote a stalled result");

endmodule
